// ===== src/rrgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrgs_pkg
// Shared constants and codes for the rounded-rectangle gradient shader.
// ----------------------------------------------------------------------------
`default_nettype none

package rrgs_pkg;

  localparam int SURFACE_MAX_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 56;  // 12 + 12 + 32
  localparam int OUT_TDATA_W = 48;  // 32 + 16

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_TOPCOL = 3'd5,
    REG_BOTCOL = 3'd6
  } cfg_reg_t;

  // Square root: 62-bit radicand, 31-bit root
  localparam int SQRT_RW = 62;

  // Gradient divider: (num << 16) / height
  localparam int TDIV_NW = 32;
  localparam int TDIV_DW = 16;
  localparam int TDIV_QW = 16;

  // Color divider: (2n + oa) / (2oa), three lanes
  localparam int CDIV_NW = 41;
  localparam int CDIV_DW = 33;
  localparam int CDIV_QW = 8;
  localparam int CDIV_LANES = 3;

  // Blend scale 255 * 65536 and half of it
  localparam logic [23:0] K_BLEND = 24'd16711680;
  localparam logic [32:0] HALF_K  = 33'd8355840;

endpackage

`default_nettype wire

// ===== src/rrgs_div.sv =====
// ----------------------------------------------------------------------------
// rrgs_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rrgs_div #(
  parameter int LANES = 1,
  parameter int NW    = 32,
  parameter int DW    = 16,
  parameter int QW    = 16,
  parameter int SW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   out_quo,
  output logic [SW-1:0]              out_side
);

  // Requires num < den << QW.
  localparam int CW = (NW > DW + QW - 1) ? NW : DW + QW - 1;

  logic                     vld  [QW];
  logic [LANES-1:0][NW-1:0] rem  [QW];
  logic [LANES-1:0][QW-1:0] quo  [QW];
  logic [DW-1:0]            den  [QW];
  logic [SW-1:0]            side [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic                     v_in;
    logic [LANES-1:0][NW-1:0] rem_in, rem_next;
    logic [LANES-1:0][QW-1:0] quo_in, quo_next;
    logic [DW-1:0]            den_in;
    logic [SW-1:0]            side_in;
    logic [CW-1:0]            dsh;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[s-1];
      assign rem_in  = rem[s-1];
      assign quo_in  = quo[s-1];
      assign den_in  = den[s-1];
      assign side_in = side[s-1];
    end

    assign dsh = CW'(den_in) << SH;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] r_ext;
      logic          hit;
      assign r_ext       = CW'(rem_in[l]);
      assign hit         = r_ext >= dsh;
      assign rem_next[l] = hit ? NW'(r_ext - dsh) : rem_in[l];
      assign quo_next[l] = quo_in[l] | (QW'(hit) << SH);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s]  <= v_in;
        rem[s]  <= rem_next;
        quo[s]  <= quo_next;
        den[s]  <= den_in;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

`default_nettype wire

// ===== src/rrgs_isqrt.sv =====
// ----------------------------------------------------------------------------
// rrgs_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module rrgs_isqrt #(
  parameter int RW = 62,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [RW-1:0]   in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW/2-1:0] out_root,
  output logic [SW-1:0]   out_side
);

  localparam int HW = RW / 2;

  logic          vld  [HW];
  logic [RW-1:0] rem  [HW];
  logic [RW-1:0] res  [HW];
  logic [SW-1:0] side [HW];

  for (genvar s = 0; s < HW; s++) begin : g_stage
    localparam int J = HW - 1 - s;
    logic          v_in, hit;
    logic [RW-1:0] rem_in, res_in, bitv, trial, rem_next, res_next;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rad;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = vld[s-1];
      assign rem_in  = rem[s-1];
      assign res_in  = res[s-1];
      assign side_in = side[s-1];
    end

    assign bitv     = RW'(1) << (2 * J);
    assign trial    = res_in + bitv;
    assign hit      = rem_in >= trial;
    assign rem_next = hit ? rem_in - trial : rem_in;
    assign res_next = hit ? (res_in >> 1) + bitv : res_in >> 1;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s]  <= v_in;
        rem[s]  <= rem_next;
        res[s]  <= res_next;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[HW-1];
  assign out_root  = res[HW-1][HW-1:0];
  assign out_side  = side[HW-1];

endmodule

`default_nettype wire

// ===== src/rounded_rect_gradient_shader_core.sv =====
// A pixel passes stage 1, the gradient divider, stages 2 and 3, the square root,
// stages C1 to C5, the color divider and the output register, in that order.
// Throughput: one pixel per cycle, sustained; the pipeline stalls as a whole
// only when the output register and its skid stage are both full.
// Depth is set by the 31-stage square root, the 16-stage gradient divider and
// the 8-stage color divider.
// Reset (rst, synchronous) clears all valid bits and the configuration registers to 0.
// ----------------------------------------------------------------------------
// rounded_rect_gradient_shader_core
// Antialiased rounded-rectangle fill with vertical gradient and source-over
// blend; one pixel in, one pixel out, the destination passed through unblended when not written.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_rect_gradient_shader_core #(
  parameter int SURFACE_MAX = rrgs_pkg::SURFACE_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rrgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrgs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], dest_pixel[55:24]
  input  logic [rrgs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_pixel[31:0], coverage[47:32]
  output logic [rrgs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // write_enable[0]
  output logic                              m_axis_tuser
);

  // --------------------------------------------------------------------------
  // Sideband types
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic signed [19:0] qx;
    logic signed [19:0] qy;
    logic               tz;    // t forced to zero
    logic               tf;    // t forced to one
    logic [31:0]        dest;
    logic               on;    // pixel on the surface
  } sb1_t;

  typedef struct packed {
    logic signed [17:0] moff;  // min(max(qx,qy),0) - r
    logic [16:0]        t;
    logic [31:0]        dest;
    logic               on;
  } sb3_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [31:0] dest;
    logic [15:0] cov;
    logic        we;
  } sb5_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [16:0] rect_left, rect_top;
  logic [15:0] rect_width, rect_height, corner_radius;
  logic [31:0] top_color, bottom_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_width    <= '0;
      rect_height   <= '0;
      corner_radius <= '0;
      top_color     <= '0;
      bottom_color  <= '0;
    end else if (cfg_write) begin
      unique case (rrgs_pkg::cfg_reg_t'(cfg_index))
        rrgs_pkg::REG_LEFT:   rect_left     <= cfg_data[16:0];
        rrgs_pkg::REG_TOP:    rect_top      <= cfg_data[16:0];
        rrgs_pkg::REG_WIDTH:  rect_width    <= cfg_data[15:0];
        rrgs_pkg::REG_HEIGHT: rect_height   <= cfg_data[15:0];
        rrgs_pkg::REG_RADIUS: corner_radius <= cfg_data[15:0];
        rrgs_pkg::REG_TOPCOL: top_color     <= cfg_data;
        rrgs_pkg::REG_BOTCOL: bottom_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derived geometry, 1/32 pixel: r = min(2*radius, w, h), centre = 2*edge + size
  logic [16:0] rad2;
  logic [15:0] min_wh, rr, hxr, hyr;
  logic [18:0] cx, cy;

  assign rad2   = {corner_radius, 1'b0};
  assign min_wh = (rect_width < rect_height) ? rect_width : rect_height;
  assign rr     = (rad2 < {1'b0, min_wh}) ? rad2[15:0] : min_wh;
  assign hxr    = rect_width - rr;
  assign hyr    = rect_height - rr;
  assign cx     = {rect_left[16], rect_left, 1'b0} + {3'b000, rect_width};
  assign cy     = {rect_top[16], rect_top, 1'b0} + {3'b000, rect_height};

  // --------------------------------------------------------------------------
  // Flow control: one global enable, output register plus one skid entry
  // --------------------------------------------------------------------------
  logic en;
  logic out_v, skid_v;
  logic [rrgs_pkg::OUT_TDATA_W-1:0] out_d, skid_d;
  logic out_u, skid_u;

  assign en            = !skid_v;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: per-axis distance q and gradient numerator
  // --------------------------------------------------------------------------
  logic [11:0] px, py;
  logic [19:0] dx, dy, adx, ady;
  logic [18:0] num;
  sb1_t        s1_in;

  assign px = s_axis_tdata[11:0];
  assign py = s_axis_tdata[23:12];
  assign dx = {3'b000, px, 5'b10000} - {cx[18], cx};
  assign dy = {3'b000, py, 5'b10000} - {cy[18], cy};
  assign adx = dx[19] ? (~dx + 20'd1) : dx;
  assign ady = dy[19] ? (~dy + 20'd1) : dy;
  assign num = {3'b000, py, 4'b1000} - {{2{rect_top[16]}}, rect_top};

  assign s1_in.qx   = adx - {4'b0000, hxr};
  assign s1_in.qy   = ady - {4'b0000, hyr};
  assign s1_in.tz   = (rect_height <= 16'd16) || num[18] || (num == '0);
  assign s1_in.tf   = !s1_in.tz && (num >= {3'b000, rect_height});
  assign s1_in.dest = s_axis_tdata[55:24];
  assign s1_in.on   = (32'(px) < SURFACE_MAX) && (32'(py) < SURFACE_MAX);

  logic        s1_v;
  sb1_t        s1_sb;
  logic [15:0] s1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v   <= s_axis_tvalid;
      s1_sb  <= s1_in;
      s1_num <= num[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Gradient divider: t = (num << 16) / height, valid when 0 < num < height
  // --------------------------------------------------------------------------
  logic                                 td_v;
  logic [0:0][rrgs_pkg::TDIV_QW-1:0]    td_quo;
  sb1_t                                 td_sb;

  rrgs_div #(
    .LANES (1),
    .NW    (rrgs_pkg::TDIV_NW),
    .DW    (rrgs_pkg::TDIV_DW),
    .QW    (rrgs_pkg::TDIV_QW),
    .SW    ($bits(sb1_t))
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_v),
    .in_num    ({s1_num, 16'h0000}),
    .in_den    (rect_height),
    .in_side   (s1_sb),
    .out_valid (td_v),
    .out_quo   (td_quo),
    .out_side  (td_sb)
  );

  // --------------------------------------------------------------------------
  // Stage 2: squares of the outside parts, corner offset, final t
  // --------------------------------------------------------------------------
  logic [18:0]        ax, ay;
  logic signed [19:0] qmax, qmin0;
  sb3_t               s2_in;

  assign ax    = td_sb.qx[19] ? 19'd0 : td_sb.qx[18:0];
  assign ay    = td_sb.qy[19] ? 19'd0 : td_sb.qy[18:0];
  assign qmax  = (td_sb.qx > td_sb.qy) ? td_sb.qx : td_sb.qy;
  assign qmin0 = qmax[19] ? qmax : 20'sd0;

  assign s2_in.moff = qmin0[17:0] - {2'b00, rr};
  assign s2_in.t    = td_sb.tz ? 17'd0 :
                      td_sb.tf ? 17'h10000 : {1'b0, td_quo[0]};
  assign s2_in.dest = td_sb.dest;
  assign s2_in.on   = td_sb.on;

  logic        s2_v;
  logic [37:0] s2_ax2, s2_ay2;
  sb3_t        s2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v   <= td_v;
      s2_ax2 <= 38'(ax) * 38'(ax);
      s2_ay2 <= 38'(ay) * 38'(ay);
      s2_sb  <= s2_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: radicand (ax^2 + ay^2) << 22
  // --------------------------------------------------------------------------
  logic                         s3_v;
  logic [rrgs_pkg::SQRT_RW-1:0] s3_rad;
  sb3_t                         s3_sb;
  logic [38:0]                  sum2;

  assign sum2 = 39'(s2_ax2) + 39'(s2_ay2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v   <= s2_v;
      s3_rad <= {1'b0, sum2, 22'h000000};
      s3_sb  <= s2_sb;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: length of the outside vector in 1/65536 pixel
  // --------------------------------------------------------------------------
  logic                           sq_v;
  logic [rrgs_pkg::SQRT_RW/2-1:0] sq_len;
  sb3_t                           sq_sb;

  rrgs_isqrt #(
    .RW (rrgs_pkg::SQRT_RW),
    .SW ($bits(sb3_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_v),
    .in_rad    (s3_rad),
    .in_side   (s3_sb),
    .out_valid (sq_v),
    .out_root  (sq_len),
    .out_side  (sq_sb)
  );

  // --------------------------------------------------------------------------
  // C1: coverage and gradient source color
  // --------------------------------------------------------------------------
  logic [32:0] sdist;
  logic [33:0] cdiff;
  logic [16:0] covi;
  logic [3:0][7:0] src;

  assign sdist = {2'b00, sq_len} + {{4{sq_sb.moff[17]}}, sq_sb.moff, 11'h000};
  assign cdiff = 34'd32768 - {sdist[32], sdist};
  assign covi  = cdiff[33] ? 17'd0 :
                 (cdiff > 34'd65536) ? 17'h10000 : cdiff[16:0];

  for (genvar i = 0; i < 4; i++) begin : g_src
    logic [7:0]         ca, cb;
    logic signed [8:0]  cdel;
    logic signed [17:0] ts;
    logic signed [26:0] prod;
    logic [27:0]        acc;
    assign ca   = top_color[8*i +: 8];
    assign cb   = bottom_color[8*i +: 8];
    assign cdel = {1'b0, cb} - {1'b0, ca};
    assign ts   = {1'b0, sq_sb.t};
    assign prod = cdel * ts;
    assign acc  = {4'h0, ca, 16'h0000} + {prod[26], prod} + 28'd32768;
    assign src[i] = acc[23:16];
  end

  logic            c1_v, c1_on;
  logic [16:0]     c1_cov;
  logic [3:0][7:0] c1_src;
  logic [31:0]     c1_dest;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (en) begin
      c1_v    <= sq_v;
      c1_cov  <= covi;
      c1_src  <= src;
      c1_dest <= sq_sb.dest;
      c1_on   <= sq_sb.on;
    end
  end

  // --------------------------------------------------------------------------
  // C2: scaled source alpha SA and K - SA
  // --------------------------------------------------------------------------
  logic [24:0] sa_full;
  assign sa_full = 25'(c1_src[3]) * 25'(c1_cov);

  logic            c2_v, c2_we;
  logic [23:0]     c2_sa, c2_ksa;
  logic [2:0][7:0] c2_src;
  logic [31:0]     c2_dest;
  logic [15:0]     c2_cov;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v    <= c1_v;
      c2_sa   <= sa_full[23:0];
      c2_ksa  <= rrgs_pkg::K_BLEND - sa_full[23:0];
      c2_src  <= c1_src[2:0];
      c2_dest <= c1_dest;
      c2_cov  <= c1_cov[16] ? 16'hFFFF : c1_cov[15:0];
      c2_we   <= c1_on && (c1_cov != '0) && (c1_src[3] != '0);
    end
  end

  // --------------------------------------------------------------------------
  // C3: dst_alpha*(K-SA), 255*SA, src*SA
  // --------------------------------------------------------------------------
  logic             c3_v, c3_we;
  logic [31:0]      c3_p, c3_s255;
  logic [2:0][31:0] c3_m;
  logic [31:0]      c3_dest;
  logic [15:0]      c3_cov;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
    end else if (en) begin
      c3_v    <= c2_v;
      c3_p    <= 32'(c2_dest[31:24]) * 32'(c2_ksa);
      c3_s255 <= (32'(c2_sa) << 8) - 32'(c2_sa);
      for (int i = 0; i < 3; i++) begin
        c3_m[i] <= 32'(c2_src[i]) * 32'(c2_sa);
      end
      c3_dest <= c2_dest;
      c3_cov  <= c2_cov;
      c3_we   <= c2_we;
    end
  end

  // --------------------------------------------------------------------------
  // C4: OA and the channel numerators n
  // --------------------------------------------------------------------------
  logic             c4_v, c4_we;
  logic [31:0]      c4_oa;
  logic [2:0][39:0] c4_n;
  logic [31:0]      c4_dest;
  logic [15:0]      c4_cov;

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_v <= 1'b0;
    end else if (en) begin
      c4_v  <= c3_v;
      c4_oa <= c3_s255 + c3_p;
      for (int i = 0; i < 3; i++) begin
        c4_n[i] <= ((40'(c3_m[i]) << 8) - 40'(c3_m[i]))
                   + 40'(c3_dest[8*i +: 8]) * 40'(c3_p);
      end
      c4_dest <= c3_dest;
      c4_cov  <= c3_cov;
      c4_we   <= c3_we;
    end
  end

  // --------------------------------------------------------------------------
  // C5: divider operands; alpha = round(OA / K) as ((OA + K/2) >> 16) / 255
  // --------------------------------------------------------------------------
  logic [32:0] hsum;
  logic [16:0] hq, aq;

  assign hsum = 33'(c4_oa) + rrgs_pkg::HALF_K;
  assign hq   = hsum[32:16];
  assign aq   = hq + 17'd1 + (hq >> 8);

  logic                                             c5_v;
  logic [rrgs_pkg::CDIV_LANES-1:0][rrgs_pkg::CDIV_NW-1:0] c5_num;
  logic [rrgs_pkg::CDIV_DW-1:0]                     c5_den;
  sb5_t                                             c5_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      c5_v <= 1'b0;
    end else if (en) begin
      c5_v <= c4_v;
      for (int i = 0; i < rrgs_pkg::CDIV_LANES; i++) begin
        c5_num[i] <= {c4_n[i], 1'b0} + 41'(c4_oa);
      end
      c5_den      <= {c4_oa, 1'b0};
      c5_sb.alpha <= aq[15:8];
      c5_sb.dest  <= c4_dest;
      c5_sb.cov   <= c4_cov;
      c5_sb.we    <= c4_we;
    end
  end

  // --------------------------------------------------------------------------
  // Color divider: round(n / OA) per channel
  // --------------------------------------------------------------------------
  logic                                                   cd_v;
  logic [rrgs_pkg::CDIV_LANES-1:0][rrgs_pkg::CDIV_QW-1:0] cd_quo;
  sb5_t                                                   cd_sb;

  rrgs_div #(
    .LANES (rrgs_pkg::CDIV_LANES),
    .NW    (rrgs_pkg::CDIV_NW),
    .DW    (rrgs_pkg::CDIV_DW),
    .QW    (rrgs_pkg::CDIV_QW),
    .SW    ($bits(sb5_t))
  ) u_cdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c5_v),
    .in_num    (c5_num),
    .in_den    (c5_den),
    .in_side   (c5_sb),
    .out_valid (cd_v),
    .out_quo   (cd_quo),
    .out_side  (cd_sb)
  );

  // --------------------------------------------------------------------------
  // Output register and skid entry
  // --------------------------------------------------------------------------
  logic [31:0]                      pix;
  logic [rrgs_pkg::OUT_TDATA_W-1:0] res_d;

  assign pix   = cd_sb.we ? {cd_sb.alpha, cd_quo[2], cd_quo[1], cd_quo[0]}
                          : cd_sb.dest;
  assign res_d = {cd_sb.cov, pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_axis_tready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        out_d  <= skid_d;
        out_u  <= skid_u;
        skid_v <= 1'b0;
      end else begin
        out_v <= cd_v;
        out_d <= res_d;
        out_u <= cd_sb.we;
      end
    end else if (en && cd_v) begin
      // output held: park the arriving transaction
      skid_v <= 1'b1;
      skid_d <= res_d;
      skid_u <= cd_sb.we;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_d;
  assign m_axis_tuser  = out_u;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !m_axis_tready))
    else $error("skid entry filled without an output stall");

  a_write_has_cov: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:32] != 16'h0000))
    else $error("pixel written with zero coverage");

endmodule

`default_nettype wire
